>>> rtl/hj_pkg.sv
// Shared types and codes for the hash join build and probe engine.
package hj_pkg;

	localparam int unsigned DataW = 32;

	typedef enum logic [1:0] {
		OP_BUILD = 2'd0,
		OP_PROBE = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		RS_JOINED  = 3'd0,
		RS_NOMATCH = 3'd1,
		RS_STORED  = 3'd2,
		RS_DROPPED = 3'd3,
		RS_CLEARED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_SCAN,
		SQ_FLUSH
	} seq_state_t;

	typedef struct packed {
		logic [1:0]              op;
		logic signed [DataW-1:0] key;
		logic signed [DataW-1:0] payload;
	} req_t;

	typedef struct packed {
		status_t                 status;
		logic signed [DataW-1:0] left_value;
		logic signed [DataW-1:0] join_key;
		logic signed [DataW-1:0] right_value;
		logic                    last;
	} rsp_t;

	typedef struct packed {
		logic signed [DataW-1:0] key;
		logic signed [DataW-1:0] value;
	} row_t;

endpackage

>>> rtl/hj_ifs.sv
// Handshake channel interfaces for the request and result streams.
interface hj_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic signed [31:0] key;
	logic signed [31:0] payload;

	modport source (output valid, op, key, payload, input ready);
	modport sink   (input valid, op, key, payload, output ready);
endinterface

interface hj_rsp_if;
	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic signed [31:0] left_value;
	logic signed [31:0] join_key;
	logic signed [31:0] right_value;
	logic              last;

	modport source (output valid, status, left_value, join_key, right_value, last,
		input ready);
	modport sink   (input valid, status, left_value, join_key, right_value, last,
		output ready);
endinterface

>>> rtl/hj_table.sv
// Row store of the build relation: one write port, one registered read port.
module hj_table #(
	parameter int unsigned TABLE_DEPTH = 64,
	parameter int unsigned AW          = 6
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  hj_pkg::row_t    wrow,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output hj_pkg::row_t    rrow
);
	import hj_pkg::*;

	row_t row_mem_q [TABLE_DEPTH];
	row_t rrow_q;

	always_ff @(posedge clk) begin
		if (we) begin
			row_mem_q[waddr] <= wrow;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rrow_q <= row_mem_q[raddr];
		end
	end

	assign rrow = rrow_q;

endmodule

>>> rtl/hj_seq.sv
// Sequencer that stores rows, scans the table with one key comparator and forms results.
module hj_seq #(
	parameter int unsigned TABLE_DEPTH = 64,
	parameter int unsigned AW          = 6,
	parameter int unsigned CW          = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_fire,
	input  hj_pkg::req_t  req_item,
	input  logic          out_free,
	output logic          req_ready,
	output logic          emit,
	output hj_pkg::rsp_t  emit_item,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output hj_pkg::row_t  mem_wrow,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  hj_pkg::row_t  mem_rrow
);
	import hj_pkg::*;

	seq_state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] last_idx;
	logic          pend_q;
	logic signed [DataW-1:0] pend_val_q;
	logic signed [DataW-1:0] key_q;
	logic signed [DataW-1:0] pay_q;

	logic key_match;
	logic scan_go;
	logic scan_end;
	logic table_full;
	logic cnt_inc, cnt_clr, probe_start, scan_adv, pend_load;

	assign last_idx   = AW'(count_q - CW'(1));
	assign key_match  = (mem_rrow.key == key_q);
	assign scan_go    = !(key_match && pend_q && !out_free);
	assign scan_end   = (idx_q == last_idx);
	assign table_full = (count_q >= CW'(TABLE_DEPTH));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE: begin
				if (req_fire && op_t'(req_item.op) == OP_PROBE && count_q != '0) begin
					state_d = SQ_SCAN;
				end
			end
			SQ_SCAN: begin
				if (scan_go && scan_end) begin
					state_d = SQ_FLUSH;
				end
			end
			SQ_FLUSH: begin
				if (out_free) begin
					state_d = SQ_IDLE;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		req_ready   = 1'b0;
		emit        = 1'b0;
		emit_item   = '{status: RS_NOMATCH, left_value: '0, join_key: key_q,
			right_value: '0, last: 1'b1};
		mem_we      = 1'b0;
		mem_waddr   = count_q[AW-1:0];
		mem_wrow    = '{key: req_item.key, value: req_item.payload};
		mem_re      = 1'b0;
		mem_raddr   = '0;
		cnt_inc     = 1'b0;
		cnt_clr     = 1'b0;
		probe_start = 1'b0;
		scan_adv    = 1'b0;
		pend_load   = 1'b0;
		unique case (state_q)
			SQ_IDLE: begin
				req_ready          = out_free;
				emit_item.join_key = req_item.key;
				if (req_fire) begin
					unique case (op_t'(req_item.op))
						OP_BUILD: begin
							emit = 1'b1;
							if (table_full) begin
								emit_item.status = RS_DROPPED;
							end else begin
								emit_item.status = RS_STORED;
								mem_we  = 1'b1;
								cnt_inc = 1'b1;
							end
						end
						OP_CLEAR: begin
							emit             = 1'b1;
							emit_item.status = RS_CLEARED;
							cnt_clr          = 1'b1;
						end
						OP_PROBE: begin
							if (count_q == '0) begin
								emit                  = 1'b1;
								emit_item.right_value = req_item.payload;
							end else begin
								probe_start = 1'b1;
								mem_re      = 1'b1;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			SQ_SCAN: begin
				if (scan_go) begin
					// A held match goes out only once a later match proves it is not the last.
					if (key_match) begin
						pend_load = 1'b1;
						if (pend_q) begin
							emit      = 1'b1;
							emit_item = '{status: RS_JOINED, left_value: pend_val_q,
								join_key: key_q, right_value: pay_q, last: 1'b0};
						end
					end
					if (!scan_end) begin
						scan_adv  = 1'b1;
						mem_re    = 1'b1;
						mem_raddr = AW'(idx_q + AW'(1));
					end
				end
			end
			SQ_FLUSH: begin
				if (out_free) begin
					emit = 1'b1;
					if (pend_q) begin
						emit_item = '{status: RS_JOINED, left_value: pend_val_q,
							join_key: key_q, right_value: pay_q, last: 1'b1};
					end else begin
						emit_item.right_value = pay_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_clr) begin
				count_q <= '0;
			end else if (cnt_inc) begin
				count_q <= CW'(count_q + CW'(1));
			end
			if (probe_start) begin
				idx_q  <= '0;
				pend_q <= 1'b0;
			end else begin
				if (scan_adv) begin
					idx_q <= AW'(idx_q + AW'(1));
				end
				if (pend_load) begin
					pend_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (probe_start) begin
			key_q <= req_item.key;
			pay_q <= req_item.payload;
		end
		if (pend_load) begin
			pend_val_q <= mem_rrow.value;
		end
	end

endmodule

>>> rtl/hash_join_build_probe.sv
// Top level of the hash join engine: channel binding, result register and the row store.
//
// Usage: requests arrive on req (op, key, payload) and results leave on rsp
// (status, left_value, join_key, right_value, last), both valid/ready channels.
// A build stores the row at the end of the table, or reports it dropped when the
// table holds TABLE_DEPTH rows; a clear empties the table; each gives one result.
// A probe compares the stored rows in insertion order, one row per cycle while
// results drain, through a single key comparator, and gives one joined result
// per match or a single no-match result. The final result of every transaction
// carries last. A build, clear or probe of an empty table shows its result in
// the cycle after acceptance. A probe reads the stored rows through the one read
// port of the row store, and its last result follows the read of the final row.
// The engine takes one request at a time; req.ready is low while a probe scans.
// Results pass through a single output register: when rsp.ready is low the scan
// holds at the next match and no request is taken until the register drains.
// After reset the table is empty; the stored rows themselves are not cleared.
module hash_join_build_probe #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	hj_req_if.sink        req,
	hj_rsp_if.source      rsp
);
	import hj_pkg::*;

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	req_t          req_item;
	rsp_t          emit_item;
	rsp_t          rsp_q;
	logic          rsp_valid_q;
	logic          out_free;
	logic          req_ready;
	logic          req_fire;
	logic          emit;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	row_t          mem_wrow, mem_rrow;

	assign req_item  = '{op: req.op, key: req.key, payload: req.payload};
	assign req.ready = req_ready;
	assign req_fire  = req.valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	hj_seq #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.AW          (AW),
		.CW          (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_fire  (req_fire),
		.req_item  (req_item),
		.out_free  (out_free),
		.req_ready (req_ready),
		.emit      (emit),
		.emit_item (emit_item),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wrow  (mem_wrow),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rrow  (mem_rrow)
	);

	hj_table #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.AW          (AW)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wrow  (mem_wrow),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rrow  (mem_rrow)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= emit_item;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.left_value  = rsp_q.left_value;
	assign rsp.join_key    = rsp_q.join_key;
	assign rsp.right_value = rsp_q.right_value;
	assign rsp.last        = rsp_q.last;

endmodule

>>> sim/hj_join_checker.sv
// Checker that predicts join results from accepted requests and compares them with the result stream.
module hj_join_checker #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	hj_req_if           req,
	hj_rsp_if           rsp,
	output int unsigned fail_count,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import hj_pkg::*;

	logic [DataW-1:0] row_keys   [TABLE_DEPTH];
	logic [DataW-1:0] row_values [TABLE_DEPTH];
	int unsigned      row_total;
	rsp_t             pending_results[$];
	int unsigned      mismatches;

	task automatic push_result(input status_t status, input logic [DataW-1:0] left_value,
		input logic [DataW-1:0] key, input logic [DataW-1:0] right_value, input logic last);
		rsp_t item;
		item.status      = status;
		item.left_value  = left_value;
		item.join_key    = key;
		item.right_value = right_value;
		item.last        = last;
		pending_results = {pending_results, item};
	endtask

	task automatic predict_join(input logic [1:0] op, input logic [DataW-1:0] key,
		input logic [DataW-1:0] payload);
		int unsigned idx;
		int unsigned hits;
		int unsigned emitted;
		hits = 0;
		emitted = 0;
		case (op)
		OP_BUILD: begin
			if (row_total < TABLE_DEPTH) begin
				row_keys[row_total]   = key;
				row_values[row_total] = payload;
				row_total++;
				push_result(RS_STORED, '0, key, '0, 1'b1);
			end else begin
				push_result(RS_DROPPED, '0, key, '0, 1'b1);
			end
		end
		OP_CLEAR: begin
			row_total = 0;
			push_result(RS_CLEARED, '0, key, '0, 1'b1);
		end
		OP_PROBE: begin
			// Count the matches first so that the final joined row can carry last.
			for (idx = 0; idx < row_total; idx++)
				if (row_keys[idx] == key)
					hits++;
			if (hits == 0) begin
				push_result(RS_NOMATCH, '0, key, payload, 1'b1);
			end else begin
				for (idx = 0; idx < row_total; idx++) begin
					if (row_keys[idx] == key) begin
						emitted++;
						push_result(RS_JOINED, row_values[idx], key, payload, emitted == hits);
					end
				end
			end
		end
		default: begin
			// The spare opcode touches nothing and answers as a bare no-match.
			push_result(RS_NOMATCH, '0, key, '0, 1'b1);
		end
		endcase
	endtask

	task automatic compare_field(input string name, input logic [DataW-1:0] want,
		input logic [DataW-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			row_total = 0;
			pending_results.delete();
			mismatches = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (req.valid && req.ready)
				predict_join(req.op, req.key, req.payload);
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result mismatch, expected none, got status %0d key %h last %b",
						$time, rsp.status, rsp.join_key, rsp.last);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					compare_field("status", DataW'(want.status), DataW'(rsp.status));
					compare_field("left_value", want.left_value, rsp.left_value);
					compare_field("join_key", want.join_key, rsp.join_key);
					compare_field("right_value", want.right_value, rsp.right_value);
					compare_field("last", DataW'(want.last), DataW'(rsp.last));
				end
			end
			fail_count <= mismatches;
			outstanding <= pending_results.size();
		end
	end

endmodule

>>> sim/tb.sv
// Testbench top: drives join requests with random pacing, back-pressures results and gives the verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hj_pkg::*;

	localparam int unsigned TableDepth  = 64;
	localparam int unsigned RandomItems = 470;
	localparam int unsigned IdleLimit   = 5000;
	localparam int unsigned TailCycles  = 2 * TableDepth + 10;
	localparam int unsigned PoolSize    = 8;
	localparam logic [1:0]  OpUnused    = 2'd3;
	localparam logic [31:0] WordMin     = 32'h8000_0000;
	localparam logic [31:0] WordMax     = 32'h7fff_ffff;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        calm = 1'b0;
	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned idle_cycles = 0;
	int unsigned stall_len;
	int unsigned sent;
	int unsigned fills;
	int unsigned roll;
	logic [31:0] fill_key;
	logic [31:0] key_pool [PoolSize];

	hj_req_if req_ch();
	hj_rsp_if rsp_ch();

	hash_join_build_probe #(
		.TABLE_DEPTH(TableDepth)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	hj_join_checker #(
		.TABLE_DEPTH(TableDepth)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #2 clk = ~clk;

	// Mostly back-to-back or short pauses, with the odd long one; none during a calm stretch.
	function automatic int unsigned pick_gap();
		int unsigned chance;
		if (calm)
			return 0;
		chance = $urandom_range(0, 99);
		if (chance < 55)
			return 0;
		if (chance < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] pick_payload();
		case ($urandom_range(0, 39))
		0: return WordMin;
		1: return WordMax;
		2: return '0;
		3: return '1;
		default: return $urandom;
		endcase
	endfunction

	// Keys come mostly from a small pool so that probes find matches.
	function automatic logic [31:0] pick_key();
		if ($urandom_range(0, 3) != 0)
			return key_pool[$urandom_range(0, PoolSize - 1)];
		return pick_payload();
	endfunction

	task automatic refresh_pool();
		foreach (key_pool[i])
			key_pool[i] = pick_payload();
	endtask

	task automatic send(input logic [1:0] op, input logic [31:0] key, input logic [31:0] payload);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.op      <= op;
		req_ch.key     <= key;
		req_ch.payload <= payload;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			stall_len = pick_gap();
			if (stall_len != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// Ends the run when no transaction moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		req_ch.valid   <= 1'b0;
		req_ch.op      <= OP_BUILD;
		req_ch.key     <= '0;
		req_ch.payload <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		refresh_pool();

		send(OP_PROBE, '0, WordMax);
		send(OpUnused, WordMin, WordMax);
		send(OP_BUILD, WordMin, WordMax);
		send(OP_BUILD, WordMax, WordMin);
		send(OP_BUILD, '0, '1);
		send(OP_BUILD, '1, '0);
		send(OP_BUILD, WordMin, 32'h1234_5678);
		// Two rows share this key and must come back in insertion order.
		send(OP_PROBE, WordMin, '0);
		send(OP_PROBE, '1, WordMin);
		send(OP_PROBE, WordMax, WordMax);
		send(OP_PROBE, '0, '1);
		send(OP_PROBE, 32'h5a5a_a5a5, 32'h0f0f_f0f0);
		send(OpUnused, '1, '1);
		send(OP_CLEAR, '1, '1);
		send(OP_PROBE, WordMin, 32'h0000_0001);
		send(OP_CLEAR, WordMin, '0);

		sent = 0;
		fills = 0;
		while (sent < RandomItems) begin
			calm = ($urandom_range(0, 7) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				send(OP_CLEAR, pick_payload(), pick_payload());
				refresh_pool();
				sent++;
			end else if (roll < 13) begin
				send(OpUnused, pick_key(), pick_payload());
				sent++;
			end else if (fills < 3 && (roll < 16 || (fills == 0 && sent > 150))) begin
				// Run the table past capacity. The first fill repeats one key, so its probe
				// matches every stored row.
				send(OP_CLEAR, pick_payload(), pick_payload());
				refresh_pool();
				fill_key = pick_key();
				repeat (TableDepth + $urandom_range(1, 3)) begin
					send(OP_BUILD, (fills == 0) ? fill_key : pick_key(), pick_payload());
					sent++;
				end
				send(OP_PROBE, fill_key, pick_payload());
				sent += 2;
				fills++;
			end else if (roll < 55) begin
				repeat ($urandom_range(1, 5)) begin
					send(OP_BUILD, pick_key(), pick_payload());
					sent++;
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					send(OP_PROBE, pick_key(), pick_payload());
					sent++;
				end
			end
		end

		req_ch.valid <= 1'b0;
		calm = 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (TailCycles) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
